// ===== sv/mlpf_pkg.sv =====
// shared types and codes for the strict-priority multi-level queue
package mlpf_pkg;

  typedef logic [1:0] status_t;

  localparam status_t StOk       = 2'd0;
  localparam status_t StFull     = 2'd1;
  localparam status_t StBadLevel = 2'd2;
  localparam status_t StEmpty    = 2'd3;

  localparam logic CmdEnq = 1'b0;
  localparam logic CmdDeq = 1'b1;

endpackage

// ===== sv/mlpf_ram.sv =====
// generic single-port ram with registered read
module mlpf_ram #(
  parameter int Width = 32,
  parameter int Depth = 640
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/multi_level_priority_fifo_top.sv =====
// strict-priority queue: one ring per level, all rings in one shared ram
// Takes one command per cycle (enqueue or dequeue) and answers each with one
// result item in the next cycle; the entry ram's single port is used at most
// once per command, so the rate is one item per cycle while the result side
// keeps up, and in_ready_o follows out_ready_i when a result is waiting.
// Level 1 is served first. Head, tail and fill count of each level sit in
// flip-flops and are cleared by reset, so the queue is usable right after
// reset with no clearing pass; ram entries are only read after being written.
module multi_level_priority_fifo_top #(
  parameter int NUM_LEVELS = 5,
  parameter int RING_DEPTH = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic signed [31:0]     value_i,
  input  logic [2:0]             level_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mlpf_pkg::status_t      status_o,
  output logic signed [31:0]     out_value_o,
  output logic [2:0]             served_level_o
);
  import mlpf_pkg::*;

  localparam int LvlW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PtrW  = $clog2(RING_DEPTH);
  localparam int OccW  = $clog2(RING_DEPTH + 1);
  localparam int Depth = NUM_LEVELS * RING_DEPTH;
  localparam int AddrW = $clog2(Depth);

  logic [PtrW-1:0] head_q [NUM_LEVELS];
  logic [PtrW-1:0] tail_q [NUM_LEVELS];
  logic [OccW-1:0] occ_q  [NUM_LEVELS];

  logic              out_valid_q;
  status_t           status_q;
  logic [2:0]        lvl_q;
  logic              has_val_q;

  logic [NUM_LEVELS-1:0] nonempty;
  logic [LvlW-1:0]       enq_idx;
  logic [LvlW-1:0]       deq_idx;
  logic                  deq_any;
  logic                  bad_level;
  logic                  lvl_full;
  logic                  accept;
  logic                  enq_ok;
  logic                  deq_ok;
  status_t               status_d;
  logic [2:0]            lvl_d;
  logic [LvlW-1:0]       sel_idx;
  logic [PtrW-1:0]       sel_ptr;
  logic [AddrW-1:0]      ram_addr;
  logic [31:0]           ram_rdata;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (occ_q[i] != '0);
    end
  end

  always_comb begin
    deq_idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        deq_idx = LvlW'(i);
      end
    end
  end

  assign deq_any   = |nonempty;
  assign bad_level = (level_i == 3'd0) || (int'(level_i) > NUM_LEVELS);
  assign enq_idx   = LvlW'(level_i - 3'd1);
  assign lvl_full  = (occ_q[enq_idx] == OccW'(RING_DEPTH));

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign enq_ok     = accept && (cmd_i == CmdEnq) && !bad_level && !lvl_full;
  assign deq_ok     = accept && (cmd_i == CmdDeq) && deq_any;

  always_comb begin
    status_d = StOk;
    lvl_d    = 3'd0;
    if (cmd_i == CmdEnq) begin
      if (bad_level) begin
        status_d = StBadLevel;
      end else if (lvl_full) begin
        status_d = StFull;
      end else begin
        lvl_d = level_i;
      end
    end else begin
      if (!deq_any) begin
        status_d = StEmpty;
      end else begin
        lvl_d = 3'(deq_idx) + 3'd1;
      end
    end
  end

  assign sel_idx  = (cmd_i == CmdEnq) ? enq_idx : deq_idx;
  assign sel_ptr  = (cmd_i == CmdEnq) ? tail_q[enq_idx] : head_q[deq_idx];
  assign ram_addr = AddrW'(AddrW'(sel_idx) * AddrW'(RING_DEPTH)) + AddrW'(sel_ptr);

  mlpf_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (enq_ok),
    .re_i   (deq_ok),
    .addr_i (ram_addr),
    .wdata_i(value_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (enq_ok) begin
        tail_q[enq_idx] <= (tail_q[enq_idx] == PtrW'(RING_DEPTH - 1)) ? '0
                           : tail_q[enq_idx] + 1'b1;
        occ_q[enq_idx]  <= occ_q[enq_idx] + 1'b1;
      end
      if (deq_ok) begin
        head_q[deq_idx] <= (head_q[deq_idx] == PtrW'(RING_DEPTH - 1)) ? '0
                           : head_q[deq_idx] + 1'b1;
        occ_q[deq_idx]  <= occ_q[deq_idx] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      lvl_q     <= lvl_d;
      has_val_q <= deq_ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign served_level_o = lvl_q;
  assign out_value_o    = has_val_q ? ram_rdata : 32'sd0;

`ifndef SYNTHESIS
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> occ_q[$past(enq_idx)] == $past(occ_q[enq_idx]) + 1'b1)
    else $error("enqueue did not raise fill count");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |=> occ_q[$past(deq_idx)] == $past(occ_q[deq_idx]) - 1'b1)
    else $error("dequeue did not lower fill count");

  a_empty_true: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StEmpty) |-> (nonempty == '0))
    else $error("empty status while a level holds items");

  a_val_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && has_val_q) |-> (status_q == StOk && lvl_q != 3'd0))
    else $error("dequeued value without ok status");
`endif

endmodule

// ===== verif/multi_level_priority_fifo_top_test.sv =====
// self-checking testbench for the strict-priority multi-level queue
`timescale 1ns / 1ps

module multi_level_priority_fifo_top_test;
  import mlpf_pkg::*;

  localparam int Levels = 5;
  localparam int Depth = 128;
  localparam int StuckLimit = 1000;

  class level_queue_model;
    typedef struct {
      status_t     status;
      logic [31:0] value;
      logic [2:0]  level;
    } answer_t;

    logic [31:0] slots [Levels][Depth];
    int head [Levels];
    int tail [Levels];
    int fill [Levels];
    answer_t answers_due [$];
    int errors;
    int enq_ok;
    int deq_ok;
    int full_hits;
    int bad_hits;
    int empty_hits;

    function void note_command(logic op, logic [31:0] data, logic [2:0] lvl);
      answer_t ans;
      int q;
      ans = '{StOk, 32'd0, 3'd0};
      if (op == CmdEnq) begin
        if (lvl == 3'd0 || lvl > Levels) begin
          ans.status = StBadLevel;
          bad_hits++;
        end else begin
          q = lvl - 1;
          if (fill[q] >= Depth) begin
            ans.status = StFull;
            full_hits++;
          end else begin
            slots[q][tail[q]] = data;
            tail[q] = (tail[q] == Depth - 1) ? 0 : tail[q] + 1;
            fill[q]++;
            ans.level = lvl;
            enq_ok++;
          end
        end
      end else begin
        ans.status = StEmpty;
        for (q = 0; q < Levels; q++) begin
          if (fill[q] != 0) begin
            ans.status = StOk;
            ans.value = slots[q][head[q]];
            head[q] = (head[q] == Depth - 1) ? 0 : head[q] + 1;
            fill[q]--;
            ans.level = 3'(q + 1);
            break;
          end
        end
        if (ans.status == StOk) deq_ok++;
        else empty_hits++;
      end
      answers_due.push_back(ans);
    endfunction

    function void check_answer(status_t st, logic [31:0] v, logic [2:0] lvl);
      answer_t ans;
      if (answers_due.size() == 0) begin
        $error("result item with no command outstanding: status %0d value %0h level %0d",
               st, v, lvl);
        errors++;
        return;
      end
      ans = answers_due.pop_front();
      if (st !== ans.status) begin
        $error("status: expected %0d, got %0d", ans.status, st);
        errors++;
      end
      if (v !== ans.value) begin
        $error("out_value: expected %0h, got %0h", ans.value, v);
        errors++;
      end
      if (lvl !== ans.level) begin
        $error("served_level: expected %0d, got %0d", ans.level, lvl);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CmdEnq;
  logic signed [31:0] value = '0;
  logic [2:0]         level = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            status;
  logic signed [31:0] out_value;
  logic [2:0]         served_level;

  int send_gap_max = 0;
  int recv_gap_max = 0;
  int stuck_cycles = 0;
  level_queue_model shadow = new();

  multi_level_priority_fifo_top #(
    .NUM_LEVELS(Levels),
    .RING_DEPTH(Depth)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .value_i       (value),
    .level_i       (level),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_value_o   (out_value),
    .served_level_o(served_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) shadow.note_command(cmd, value, level);
      if (out_valid && out_ready) shadow.check_answer(status, out_value, served_level);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("no item moved for %0d cycles", StuckLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_command(input logic op, input logic [31:0] data, input logic [2:0] lvl);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    value <= data;
    level <= lvl;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    // let the monitor note the item accepted at this edge
    #1;
    while (shadow.answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_mix(input int count, input int enq_pct, input int bad_pct,
                         input int lvl_lo, input int lvl_hi);
    logic        op;
    logic [31:0] data;
    logic [2:0]  lvl;
    for (int n = 0; n < count; n++) begin
      data = $urandom;
      if ($urandom_range(15, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: data = 32'h7fff_ffff;
          1: data = 32'h8000_0000;
          2: data = 32'h0000_0000;
          default: data = 32'hffff_ffff;
        endcase
      end
      lvl = 3'($urandom_range(7, 0));
      op = CmdDeq;
      if ($urandom_range(99, 0) < enq_pct) begin
        op = CmdEnq;
        if ($urandom_range(99, 0) < bad_pct) begin
          case ($urandom_range(2, 0))
            0: lvl = 3'd0;
            1: lvl = 3'd6;
            default: lvl = 3'd7;
          endcase
        end else begin
          lvl = 3'($urandom_range(lvl_hi, lvl_lo));
        end
      end
      send_command(op, data, lvl);
    end
  endtask

  initial begin
    wait (rst_n);
    forever begin
      int gap;
      gap = $urandom_range(recv_gap_max, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int hot_level;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, bad levels, one entry per level, priority order
    send_gap_max = 3;
    recv_gap_max = 3;
    send_command(CmdDeq, 32'h1234_5678, 3'd7);
    send_command(CmdEnq, 32'h7fff_ffff, 3'd0);
    send_command(CmdEnq, 32'h8000_0000, 3'd6);
    send_command(CmdEnq, 32'hffff_ffff, 3'd7);
    send_command(CmdEnq, 32'h7fff_ffff, 3'd5);
    send_command(CmdEnq, 32'h8000_0000, 3'd4);
    send_command(CmdEnq, 32'h0000_0000, 3'd3);
    send_command(CmdEnq, 32'hffff_ffff, 3'd2);
    send_command(CmdEnq, 32'ha5a5_a5a5, 3'd1);
    send_command(CmdDeq, 32'hffff_ffff, 3'd0);
    send_command(CmdDeq, 32'h0000_0000, 3'd5);
    send_command(CmdDeq, 32'h5a5a_5a5a, 3'd2);
    send_command(CmdDeq, 32'h0000_0001, 3'd6);
    send_command(CmdDeq, 32'h8000_0000, 3'd1);
    send_command(CmdDeq, 32'h7fff_ffff, 3'd3);
    send_command(CmdEnq, 32'h5555_5555, 3'd5);
    send_command(CmdEnq, 32'haaaa_aaaa, 3'd3);
    send_command(CmdDeq, 32'h0000_0000, 3'd4);
    send_command(CmdDeq, 32'h0000_0000, 3'd0);
    send_command(CmdDeq, 32'hdead_beef, 3'd7);
    drain_results();

    send_gap_max = 17;
    recv_gap_max = 17;
    run_mix(300, 50, 6, 1, 5);
    drain_results();

    // push one level past full, then drain through empty
    hot_level = $urandom_range(5, 1);
    send_gap_max = 2;
    recv_gap_max = 0;
    run_mix(220, 85, 2, hot_level, hot_level);
    send_gap_max = 17;
    recv_gap_max = 0;
    run_mix(260, 15, 2, 1, 5);
    drain_results();

    send_gap_max = 0;
    recv_gap_max = 0;
    run_mix(300, 55, 5, 1, 5);

    send_gap_max = 17;
    recv_gap_max = 17;
    run_mix(300, 60, 5, 1, 5);
    drain_results();
    repeat (4) @(posedge clk);

    $display("enqueued %0d, dequeued %0d; answered full %0d, bad level %0d, empty %0d times",
             shadow.enq_ok, shadow.deq_ok, shadow.full_hits, shadow.bad_hits,
             shadow.empty_hits);
    if (shadow.errors == 0 && shadow.answers_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
